// ===== design/bdq_pkg.sv =====
// Package for the bounded deque core: sizes, command and status codes,
// transaction structs and the per-cell operation code.
// No dependencies.
package bdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_DUMP       = 3'd4;
	localparam logic [2:0] CMD_REVERSE    = 3'd5;
	localparam logic [2:0] CMD_CLEAR      = 3'd6;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] push_value;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic               last;
	} result_t;

	// What a cell loads at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_FROM_BUS
	} cell_op_t;

endpackage

// ===== design/bdq_cell.sv =====
// One storage cell of the deque chain: a 32-bit value that holds, takes a
// neighbor's value or takes the shared insert bus. Depends on bdq_pkg.
module bdq_cell (
	input  logic                      clk,
	input  bdq_pkg::cell_op_t         op,
	input  logic signed [31:0]        from_left,
	input  logic signed [31:0]        from_right,
	input  logic signed [31:0]        from_bus,
	output logic signed [31:0]        value
);
	import bdq_pkg::*;

	logic signed [31:0] value_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_FROM_LEFT:  value_q <= from_left;
			CELL_FROM_RIGHT: value_q <= from_right;
			CELL_FROM_BUS:   value_q <= from_bus;
			default:         value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

// ===== design/bounded_deque_with_reverse_core.sv =====
// Top level of the bounded deque core: command FSM, fill and order state,
// result register and the ring of bdq_cell instances. Depends on bdq_pkg.
//
// A command is captured in cmd_q and run in S_EXEC; its result is
// registered in rsp_q. A dump then steps through S_DUMP with one result
// per walk step, since the cell ring rotates by one cell per result. A new
// command is taken only in S_IDLE; a held result stalls S_EXEC and S_DUMP.
// Reset: arst_n clears the FSM, fill count, order flag and result valid;
// cell contents are left as they are and only written cells are ever read.
module bounded_deque_with_reverse_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  bdq_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bdq_pkg::result_t   rsp
);
	import bdq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	state_t             state_q;
	cmd_item_t          cmd_q;
	logic [CNT_W-1:0]   fill_q;
	logic               rev_q;
	logic [IDX_W-1:0]   dump_idx_q;
	logic               rsp_valid_q;
	result_t            rsp_q;

	// Cell ring; cell 0 is the physical front, cell fill_q-1 the physical back.
	logic signed [31:0] cell_val [DEPTH];
	cell_op_t           cell_op  [DEPTH];
	logic signed [31:0] cell_bus;

	logic               out_free;
	logic               exec_go;
	logic               dump_go;
	logic               is_push;
	logic               is_pop;
	logic               is_dump;
	logic               phys_front;
	logic               full;
	logic               empty;
	logic [IDX_W-1:0]   back_idx;
	logic signed [31:0] back_val;
	logic               dump_last;
	logic               rsp_load;
	result_t            rsp_next;

	// The result register parts the output side from the command side.
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign exec_go = (state_q == S_EXEC) && out_free;
	assign dump_go = (state_q == S_DUMP) && out_free;

	assign is_push = (cmd_q.command == CMD_PUSH_FRONT) || (cmd_q.command == CMD_PUSH_BACK);
	assign is_pop  = (cmd_q.command == CMD_POP_FRONT) || (cmd_q.command == CMD_POP_BACK);
	assign is_dump = (cmd_q.command == CMD_DUMP);
	// A reversal swaps which physical end the logical front sits at.
	assign phys_front = ((cmd_q.command == CMD_PUSH_FRONT) ||
	                     (cmd_q.command == CMD_POP_FRONT)) ^ rev_q;

	assign full      = (fill_q == CNT_W'(DEPTH));
	assign empty     = (fill_q == '0);
	assign back_idx  = IDX_W'(fill_q - CNT_W'(1));
	assign back_val  = cell_val[back_idx];
	assign dump_last = (dump_idx_q == back_idx);

	// Insert bus: push value for a push, the value wrapping around the
	// stored range during a dump rotation.
	always_comb begin
		if (state_q == S_DUMP) begin
			cell_bus = rev_q ? back_val : cell_val[0];
		end else begin
			cell_bus = cmd_q.push_value;
		end
	end

	// Per-cell operation. Cells past the stored range may take garbage;
	// they are never read before being written again.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_op[i] = CELL_HOLD;
			if (exec_go && is_push && !full) begin
				if (phys_front) begin
					// shift toward the back, insert at cell 0
					cell_op[i] = (i == 0) ? CELL_FROM_BUS : CELL_FROM_LEFT;
				end else if (CNT_W'(i) == fill_q) begin
					cell_op[i] = CELL_FROM_BUS;
				end
			end else if (exec_go && is_pop && !empty && phys_front) begin
				// drop cell 0, shift toward the front
				cell_op[i] = CELL_FROM_RIGHT;
			end else if (dump_go) begin
				if (!rev_q) begin
					// rotate the stored range toward the front
					if (IDX_W'(i) == back_idx) begin
						cell_op[i] = CELL_FROM_BUS;
					end else if (IDX_W'(i) < back_idx) begin
						cell_op[i] = CELL_FROM_RIGHT;
					end
				end else begin
					// rotate the stored range toward the back
					if (i == 0) begin
						cell_op[i] = CELL_FROM_BUS;
					end else if (IDX_W'(i) <= back_idx) begin
						cell_op[i] = CELL_FROM_LEFT;
					end
				end
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam int LEFT_IDX  = (g + DEPTH - 1) % DEPTH;
		localparam int RIGHT_IDX = (g + 1) % DEPTH;

		bdq_cell u_cell (
			.clk        (clk),
			.op         (cell_op[g]),
			.from_left  (cell_val[LEFT_IDX]),
			.from_right (cell_val[RIGHT_IDX]),
			.from_bus   (cell_bus),
			.value      (cell_val[g])
		);
	end

	// Next result: one per executed command, except a non-empty dump, which
	// starts the walk instead; one per walk step.
	always_comb begin
		rsp_load            = 1'b0;
		rsp_next.status     = STATUS_OK;
		rsp_next.item_value = '0;
		rsp_next.last       = 1'b1;
		if (exec_go) begin
			rsp_load = 1'b1;
			if (is_push) begin
				if (full) begin
					rsp_next.status = STATUS_FULL;
				end
			end else if (is_pop) begin
				if (empty) begin
					rsp_next.status = STATUS_EMPTY;
				end else begin
					rsp_next.item_value = phys_front ? cell_val[0] : back_val;
				end
			end else if (is_dump) begin
				if (empty) begin
					rsp_next.status = STATUS_EMPTY;
				end else begin
					// walk the ring; no result this cycle
					rsp_load = 1'b0;
				end
			end
		end else if (dump_go) begin
			rsp_load            = 1'b1;
			rsp_next.item_value = rev_q ? back_val : cell_val[0];
			rsp_next.last       = dump_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			fill_q      <= '0;
			rev_q       <= 1'b0;
			dump_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// load a new result, or retire the waiting one once it is taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_next;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// advance the fill count and order flag on an executed command
			if (exec_go) begin
				if (is_push && !full) begin
					fill_q <= fill_q + CNT_W'(1);
				end else if (is_pop && !empty) begin
					fill_q <= fill_q - CNT_W'(1);
				end else if (cmd_q.command == CMD_CLEAR) begin
					fill_q <= '0;
				end
				if (cmd_q.command == CMD_REVERSE) begin
					rev_q <= !rev_q;
				end else if (cmd_q.command == CMD_CLEAR) begin
					rev_q <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						dump_idx_q <= '0;
						state_q    <= (is_dump && !empty) ? S_DUMP : S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							dump_idx_q <= dump_idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The fill count never passes the ring size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// A dump walk only runs over a non-empty store.
	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !empty)
		else $error("dump walk on empty store");

	// A full status is only reported while the store is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_FULL) |-> full)
		else $error("full status with free cells");

	// A result that is not the last one belongs to a dump still in progress.
	a_not_last_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (state_q == S_DUMP))
		else $error("non-final result outside dump");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_with_reverse_core: runs directed and random
// commands through a valid/ready channel and checks every result against a deque predictor.
// Depends on bdq_pkg and the core RTL.
module tb_top;
	import bdq_pkg::*;

	localparam logic [2:0] CMD_UNUSED   = 3'd7;
	localparam int         LIMIT_CYCLES = 300000;
	localparam int         TAIL_CYCLES  = 24;
	localparam int         MAX_REPORTS  = 10;

	typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	cmd_item_t cmd;
	logic      rsp_valid;
	logic      rsp_ready;
	result_t   rsp;

	// Predicted deque contents: ring of slots, physical front, fill level, order flag.
	logic signed [31:0] deque_slots [DEPTH];
	int                 deque_front;
	int                 deque_fill;
	bit                 deque_flipped;

	// Results still owed by the core, oldest first.
	result_t results_due[$];

	int mismatch_count;
	int cycle_count;
	int burst_left;

	bounded_deque_with_reverse_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End the run as failed once cycle_count reaches LIMIT_CYCLES, stalled or not.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count == LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d results outstanding",
					cycle_count, results_due.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Apply one accepted command to the predicted deque and queue the results it owes.
	// A reversal only flips the order flag, so logical front maps to the physical back
	// while the flag is set.
	function automatic void deque_apply(input cmd_item_t item);
		result_t r;
		bit      at_phys_front;
		int      slot;
		r.status     = STATUS_OK;
		r.item_value = '0;
		r.last       = 1'b1;
		at_phys_front = (item.command == CMD_PUSH_FRONT || item.command == CMD_POP_FRONT)
			^ deque_flipped;
		case (item.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (deque_fill == DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					if (at_phys_front) begin
						deque_front = (deque_front + DEPTH - 1) % DEPTH;
						deque_slots[deque_front] = item.push_value;
					end else begin
						deque_slots[(deque_front + deque_fill) % DEPTH] = item.push_value;
					end
					deque_fill++;
				end
				results_due.push_back(r);
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (deque_fill == 0) begin
					r.status = STATUS_EMPTY;
				end else if (at_phys_front) begin
					r.item_value = deque_slots[deque_front];
					deque_front  = (deque_front + 1) % DEPTH;
					deque_fill--;
				end else begin
					r.item_value = deque_slots[(deque_front + deque_fill - 1) % DEPTH];
					deque_fill--;
				end
				results_due.push_back(r);
			end
			CMD_DUMP: begin
				if (deque_fill == 0) begin
					r.status = STATUS_EMPTY;
					results_due.push_back(r);
				end else begin
					// Walk from logical front to logical back, marking only the final entry.
					for (int i = 0; i < deque_fill; i++) begin
						slot = deque_flipped ? (deque_front + deque_fill - 1 - i) % DEPTH
							: (deque_front + i) % DEPTH;
						r.item_value = deque_slots[slot];
						r.last       = (i == deque_fill - 1);
						results_due.push_back(r);
					end
				end
			end
			CMD_REVERSE: begin
				deque_flipped = ~deque_flipped;
				results_due.push_back(r);
			end
			CMD_CLEAR: begin
				deque_fill    = 0;
				deque_front   = 0;
				deque_flipped = 1'b0;
				results_due.push_back(r);
			end
			default: begin
				// Unused code: no effect, plain ok status.
				results_due.push_back(r);
			end
		endcase
	endfunction

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// Send one command. The sender works in bursts; at the start of a burst it may
	// drop valid for a random gap. Valid then holds with a fixed payload until accepted.
	task automatic send_cmd(input logic [2:0] code, input logic signed [31:0] value);
		cmd_item_t item;
		int        gap;
		item.command    = code;
		item.push_value = value;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd       <= item;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		deque_apply(item);
	endtask

	// Hold the sender off until the core has delivered every owed result.
	task automatic wait_results_drained();
		cmd_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	// Pick a command; push_pct and pop_pct steer the fill level, the rest is spread
	// over dump, reverse, clear and the unused code.
	function automatic logic [2:0] pick_command(input int push_pct, input int pop_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		if (roll < push_pct + pop_pct)
			return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return CMD_DUMP;
			5, 6, 7:       return CMD_REVERSE;
			8:             return CMD_CLEAR;
			default:       return CMD_UNUSED;
		endcase
	endfunction

	// Pops, a dump, the unused code and a reversal on an empty store; the final reversal
	// leaves the order flipped so the fill test pushes through the reversed mapping.
	task automatic test_empty_store();
		send_cmd(CMD_POP_FRONT, 32'sd5);
		send_cmd(CMD_POP_BACK, -32'sd5);
		send_cmd(CMD_DUMP, '0);
		send_cmd(CMD_UNUSED, 32'sh7FFF_FFFF);
		send_cmd(CMD_REVERSE, '0);
	endtask

	// Fill to capacity from both ends with corner values, then overflow from each end.
	task automatic test_fill_to_full();
		logic signed [31:0] v;
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 8)
				0:       v = 32'sh8000_0000;
				1:       v = 32'sh7FFF_FFFF;
				2:       v = '0;
				3:       v = -32'sd1;
				4:       v = 32'sh5555_5555;
				5:       v = 32'shAAAA_AAAA;
				default: v = $urandom();
			endcase
			send_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, v);
		end
		send_cmd(CMD_PUSH_FRONT, 32'sh1234_5678);
		send_cmd(CMD_PUSH_BACK, -32'sd2);
	endtask

	// Dump a full store, flip the order and pop from both ends.
	task automatic test_reverse_and_dump();
		send_cmd(CMD_DUMP, '0);
		send_cmd(CMD_REVERSE, '0);
		send_cmd(CMD_POP_FRONT, '0);
		send_cmd(CMD_POP_BACK, '0);
	endtask

	task automatic test_clear();
		send_cmd(CMD_CLEAR, '0);
		send_cmd(CMD_DUMP, '0);
	endtask

	// Push-biased traffic: the store spends much of its time near or at full.
	task automatic test_growth_churn(input int count);
		for (int i = 0; i < count; i++)
			send_cmd(pick_command(58, 22), pick_value());
	endtask

	// Pop-biased traffic: the store keeps running dry.
	task automatic test_drain_churn(input int count);
		for (int i = 0; i < count; i++)
			send_cmd(pick_command(34, 48), pick_value());
	endtask

	// Response side: stall on a pattern of its own, picked anew after each random span,
	// from always ready through coin flips to long stalls.
	initial begin : rsp_throttle
		rx_mode_t mode;
		int       span_left;
		int       hold_left;
		rsp_ready <= 1'b0;
		mode      = RX_OPEN;
		span_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (span_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 2));
				span_left = $urandom_range(16, 64);
			end
			span_left--;
			case (mode)
				RX_OPEN: rsp_ready <= 1'b1;
				RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
				default: begin
					if (hold_left > 0) begin
						hold_left--;
						rsp_ready <= 1'b0;
					end else if ($urandom_range(0, 5) == 0) begin
						hold_left = $urandom_range(1, 8);
						rsp_ready <= 1'b0;
					end else begin
						rsp_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Result checker: compare each transaction on the response channel with the
	// oldest owed result, field by field.
	initial begin : result_check
		result_t got;
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				got = rsp;
				if (results_due.size() == 0) begin
					flag_error($sformatf("unexpected result at cycle %0d: status %0d value %0d last %0b",
						cycle_count, got.status, got.item_value, got.last));
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status || got.item_value !== want.item_value
						|| got.last !== want.last) begin
						flag_error($sformatf({"mismatch at cycle %0d: expected status %0d value %0d ",
							"last %0b, got status %0d value %0d last %0b"}, cycle_count,
							want.status, want.item_value, want.last,
							got.status, got.item_value, got.last));
					end
				end
			end
		end
	end

	initial begin : run_tests
		// Drive every input to a known value while reset is held, then release it.
		arst_n         <= 1'b0;
		cmd_valid      <= 1'b0;
		cmd            <= '0;
		mismatch_count = 0;
		burst_left     = 0;
		deque_front    = 0;
		deque_fill     = 0;
		deque_flipped  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_store();
		test_fill_to_full();
		test_reverse_and_dump();
		test_clear();
		test_growth_churn(170);
		// Let the core go fully idle once mid-run before resuming traffic.
		wait_results_drained();
		test_drain_churn(160);

		// Drop valid, wait for every owed result, then watch for strays.
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== bounded_deque_with_reverse_core.f =====
design/bdq_pkg.sv
design/bdq_cell.sv
design/bounded_deque_with_reverse_core.sv
tb/tb_top.sv
